[rtl/umul_pkg.sv]
// ----------------------------------------------------------------------------
// umul_pkg: shared types and constants of the 128x128 multiplier
// Digit layout, cell count and the bus that runs down the cell chain.
// ----------------------------------------------------------------------------
package umul_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned DigitW    = 32;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned OpW       = DigitW * NumDigits;
  localparam int unsigned ProdW     = 2 * OpW;
  localparam int unsigned PartW     = 2 * DigitW;
  localparam int unsigned NumCells  = NumDigits * NumDigits;
  localparam int unsigned Latency   = NumCells + 1;

  typedef logic [1:0] dig_sel_t;
  typedef logic [2:0] col_pos_t;

  typedef struct packed {
    dig_sel_t a_sel;
    dig_sel_t b_sel;
  } cell_sel_t;

  typedef struct packed {
    logic             vld;
    logic [OpW-1:0]   a;
    logic [OpW-1:0]   b;
    logic [ProdW-1:0] acc;
    logic [PartW-1:0] part;
    col_pos_t         pos;
  } cell_bus_t;

  function automatic logic [ProdW-1:0] place_part(logic [PartW-1:0] part, col_pos_t pos);
    logic [ProdW-1:0] wide;
    wide = {{(ProdW-PartW){1'b0}}, part};
    return wide << {pos, 5'b00000};
  endfunction

endpackage

[rtl/umul_cell.sv]
// ----------------------------------------------------------------------------
// umul_cell: one multiply-accumulate cell of the chain
// Multiplies one 32-bit digit pair and folds the previous cell's partial
// product into the running sum, then hands everything to the next cell.
// ----------------------------------------------------------------------------
module umul_cell
  import umul_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_sel_t sel_i,
  input  cell_bus_t bus_i,
  output cell_bus_t bus_o
);

  logic [DigitW-1:0] a_dig;
  logic [DigitW-1:0] b_dig;
  logic [PartW-1:0]  part_d;
  logic [ProdW-1:0]  acc_d;
  col_pos_t          pos_d;
  logic              vld_q;
  cell_bus_t         pay_q;

  assign a_dig  = bus_i.a[{sel_i.a_sel, 5'b00000} +: DigitW];
  assign b_dig  = bus_i.b[{sel_i.b_sel, 5'b00000} +: DigitW];
  assign part_d = a_dig * b_dig;
  assign acc_d  = bus_i.acc + place_part(bus_i.part, bus_i.pos);
  assign pos_d  = {1'b0, sel_i.a_sel} + {1'b0, sel_i.b_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= bus_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q.vld  <= 1'b0;
    pay_q.a    <= bus_i.a;
    pay_q.b    <= bus_i.b;
    pay_q.acc  <= acc_d;
    pay_q.part <= part_d;
    pay_q.pos  <= pos_d;
  end

  always_comb begin
    bus_o     = pay_q;
    bus_o.vld = vld_q;
  end

endmodule

[rtl/unsigned_multiply_128x128_to_256_core.sv]
// ----------------------------------------------------------------------------
// unsigned_multiply_128x128_to_256_core: full 128x128 -> 256 bit multiplier
// Schoolbook product over sixteen 32x32 digit products in a cell chain.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start_i is high; busy_o never rises,
// so one operand pair per clock is sustained. Each request runs down a chain
// of sixteen cells, one 32x32 digit product and one 256-bit accumulate per
// cell, plus an output register: its product appears on valid_o after the cell
// registers and the output register, in request order. The result is shown
// for a single cycle and is not held; the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module unsigned_multiply_128x128_to_256_core
  import umul_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [WordW-1:0] a_low_i,
  input  logic [WordW-1:0] a_high_i,
  input  logic [WordW-1:0] b_low_i,
  input  logic [WordW-1:0] b_high_i,
  output logic             valid_o,
  output logic [WordW-1:0] product_word0_o,
  output logic [WordW-1:0] product_word1_o,
  output logic [WordW-1:0] product_word2_o,
  output logic [WordW-1:0] product_word3_o
);

  cell_bus_t        bus [NumCells+1];
  cell_sel_t        sel [NumCells];
  logic             valid_q;
  logic [ProdW-1:0] product_d;
  logic [ProdW-1:0] product_q;

  assign busy_o = 1'b0;

  always_comb begin
    bus[0].vld  = start_i & ~busy_o;
    bus[0].a    = {a_high_i, a_low_i};
    bus[0].b    = {b_high_i, b_low_i};
    bus[0].acc  = '0;
    bus[0].part = '0;
    bus[0].pos  = '0;
  end

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    assign sel[k].a_sel = dig_sel_t'(k % NumDigits);
    assign sel[k].b_sel = dig_sel_t'(k / NumDigits);

    umul_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sel_i  (sel[k]),
      .bus_i  (bus[k]),
      .bus_o  (bus[k+1])
    );
  end

  assign product_d = bus[NumCells].acc + place_part(bus[NumCells].part, bus[NumCells].pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= bus[NumCells].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
  end

  assign valid_o         = valid_q;
  assign product_word0_o = product_q[0*WordW +: WordW];
  assign product_word1_o = product_q[1*WordW +: WordW];
  assign product_word2_o = product_q[2*WordW +: WordW];
  assign product_word3_o = product_q[3*WordW +: WordW];

`ifndef SYNTH
  a_req_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency valid_o)
    else $error("accepted request did not yield a result");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##Latency !valid_o)
    else $error("result without a matching request");

  a_chain_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bus[NumCells].vld |=> valid_o)
    else $error("chain output lost before the result register");
`endif

endmodule

[verif/unsigned_multiply_128x128_to_256_core_tb.sv]
// ----------------------------------------------------------------------------
// unsigned_multiply_128x128_to_256_core_tb: self-checking bench of the multiplier
// Operand pairs are queued up front and handed to the core by a clocked
// driver with random idle bursts. Each accepted request gets its 256-bit
// product predicted from four 64x64 partial products with column carries.
// A clocked monitor checks every strobed product, in order and word by word.
// ----------------------------------------------------------------------------
module unsigned_multiply_128x128_to_256_core_tb;
  import umul_pkg::*;

  localparam int unsigned NumRandom  = 1800;
  localparam int unsigned TailItems  = 200;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned MaxReports = 10;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t a_low;
    word_t a_high;
    word_t b_low;
    word_t b_high;
  } mul_req_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
  } product_t;

  logic  clk_i    = 1'b0;
  logic  rst_ni   = 1'b0;
  logic  start_i  = 1'b0;
  word_t a_low_i  = '0;
  word_t a_high_i = '0;
  word_t b_low_i  = '0;
  word_t b_high_i = '0;
  logic  busy_o;
  logic  valid_o;
  word_t product_word0_o;
  word_t product_word1_o;
  word_t product_word2_o;
  word_t product_word3_o;

  mul_req_t    operand_q[$];
  product_t    product_q[$];
  bit          stim_ready   = 1'b0;
  int unsigned total_reqs   = 0;
  int unsigned directed_cnt = 0;
  int unsigned accept_cnt   = 0;
  int unsigned checked_cnt  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned burst_cnt    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned gap_left     = 0;

  unsigned_multiply_128x128_to_256_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .a_low_i        (a_low_i),
    .a_high_i       (a_high_i),
    .b_low_i        (b_low_i),
    .b_high_i       (b_high_i),
    .valid_o        (valid_o),
    .product_word0_o(product_word0_o),
    .product_word1_o(product_word1_o),
    .product_word2_o(product_word2_o),
    .product_word3_o(product_word3_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic product_t mul_128x128(mul_req_t r);
    logic [2*WordW-1:0] ll, lh, hl, hh;
    logic [WordW+1:0]   col1;
    logic [WordW+2:0]   col2;
    product_t           p;
    ll   = {64'd0, r.a_low}  * {64'd0, r.b_low};
    lh   = {64'd0, r.a_low}  * {64'd0, r.b_high};
    hl   = {64'd0, r.a_high} * {64'd0, r.b_low};
    hh   = {64'd0, r.a_high} * {64'd0, r.b_high};
    col1 = {2'b00, ll[127:64]} + {2'b00, lh[63:0]} + {2'b00, hl[63:0]};
    col2 = {3'b000, lh[127:64]} + {3'b000, hl[127:64]} + {3'b000, hh[63:0]}
         + {65'd0, col1[65:64]};
    p.w0 = ll[63:0];
    p.w1 = col1[63:0];
    p.w2 = col2[63:0];
    p.w3 = hh[127:64] + {61'd0, col2[66:64]};
    return p;
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t edge_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 64'd1;
      2:       return '1;
      3:       return 64'h8000_0000_0000_0000;
      4:       return 64'hFFFF_FFFF_FFFF_FFFE;
      5:       return 64'h0000_0000_FFFF_FFFF;
      6:       return 64'hFFFF_FFFF_0000_0000;
      default: return word_t'(1) << $urandom_range(0, 63);
    endcase
  endfunction

  function automatic word_t mixed_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return rand_word();
      6, 7:             return edge_word();
      8:                return rand_word() & rand_word() & rand_word();
      default:          return rand_word() | rand_word() | rand_word();
    endcase
  endfunction

  task automatic add_req(word_t al, word_t ah, word_t bl, word_t bh);
    operand_q.push_back('{a_low: al, a_high: ah, b_low: bl, b_high: bh});
    total_reqs++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && busy_o) begin
      // hold the request until the core takes it
    end else begin
      if (start_i) begin
        product_q.push_back(mul_128x128('{a_low: a_low_i, a_high: a_high_i,
                                          b_low: b_low_i, b_high: b_high_i}));
        accept_cnt++;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
        a_low_i  <= rand_word();
        a_high_i <= rand_word();
        b_low_i  <= rand_word();
        b_high_i <= rand_word();
      end else if (stim_ready && operand_q.size() != 0) begin
        mul_req_t r;
        r = operand_q.pop_front();
        start_i  <= 1'b1;
        a_low_i  <= r.a_low;
        a_high_i <= r.a_high;
        b_low_i  <= r.b_low;
        b_high_i <= r.b_high;
        if (operand_q.size() > TailItems && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(1, 19);
          burst_cnt++;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (valid_o) begin
        product_t got;
        product_t want;
        got = '{w0: product_word0_o, w1: product_word1_o,
                w2: product_word2_o, w3: product_word3_o};
        if (product_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("ERROR: unexpected product %h_%h_%h_%h",
                     got.w3, got.w2, got.w1, got.w0);
          end
        end else begin
          want = product_q.pop_front();
          checked_cnt++;
          if (got.w0 !== want.w0 || got.w1 !== want.w1 ||
              got.w2 !== want.w2 || got.w3 !== want.w3) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports) begin
              $display("ERROR: product %0d word0 exp %h got %h, word1 exp %h got %h",
                       checked_cnt, want.w0, got.w0, want.w1, got.w1);
              $display("       word2 exp %h got %h, word3 exp %h got %h",
                       want.w2, got.w2, want.w3, got.w3);
            end
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("ERROR: no request or product for %0d cycles", IdleLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    add_req('0, '0, '0, '0);
    add_req('1, '1, '1, '1);
    add_req(64'd1, '0, 64'd1, '0);
    add_req('1, '1, 64'd1, '0);
    add_req(64'd1, '0, '1, '1);
    add_req('0, '0, '1, '1);
    add_req('1, '1, '0, '0);
    add_req('0, 64'h8000_0000_0000_0000, '0, 64'h8000_0000_0000_0000);
    add_req(64'h8000_0000_0000_0000, '0, 64'h8000_0000_0000_0000, '0);
    add_req('1, '0, '1, '0);
    add_req('0, '1, '0, '1);
    add_req('1, '0, '0, '1);
    add_req('0, '1, '1, '0);
    add_req('0, 64'd1, '0, 64'd1);
    add_req(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    add_req(64'hFFFF_FFFF_FFFF_FFFE, '1, 64'hFFFF_FFFF_FFFF_FFFE, '1);
    add_req(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
            64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
    add_req(64'd1, '0, '1, '0);
    add_req('1, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF);
    directed_cnt = total_reqs;
    repeat (NumRandom) begin
      if ($urandom_range(0, 2) != 0) begin
        add_req(rand_word(), rand_word(), rand_word(), rand_word());
      end else begin
        add_req(mixed_word(), mixed_word(), mixed_word(), mixed_word());
      end
    end
    stim_ready = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accept_cnt != total_reqs || product_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);

    $display("Ran %0d multiply requests (%0d directed, %0d random) with %0d idle bursts",
             accept_cnt, directed_cnt, total_reqs - directed_cnt, burst_cnt);
    $display("Checked %0d products, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && product_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
